// ===== src/hashed_lock_event_counter_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// hashed lock event counter table: assertion macros
// shared checks written as one-line macros for the rtl files
// ----------------------------------------------------------------------------
`ifndef HASHED_LOCK_EVENT_COUNTER_TABLE_TOP_DEFINES_SVH
`define HASHED_LOCK_EVENT_COUNTER_TABLE_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define HLEC_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("hlec check failed");

// condition implies consequence in the next cycle
`define HLEC_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("hlec check failed");

`endif

// ===== src/hlec_pkg.sv =====
// ----------------------------------------------------------------------------
// hlec_pkg
// types and constants shared by the lock event counter table
// ----------------------------------------------------------------------------
package hlec_pkg;

	localparam int unsigned TABLE_ENTRIES = 512;
	localparam int unsigned SLOT_W        = 9;
	localparam int unsigned KEY_W         = 48;
	localparam int unsigned TAG_W         = 32;
	localparam int unsigned CNT_W         = 32;
	localparam int unsigned PROBE_LIMIT   = 16;
	localparam int unsigned QUEUE_DEPTH   = 2;

	// request codes
	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_EVENT    = 2'd1;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_ZERO_KEY = 2'd2;

	typedef enum logic [1:0] {
		CMD_READ     = 2'd0,
		CMD_ZERO     = 2'd1,
		CMD_REGISTER = 2'd2,
		CMD_EVENT    = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [KEY_W-1:0]   key;
		logic [TAG_W-1:0]   tag;
		logic [SLOT_W-1:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  name;
		logic [CNT_W-1:0]  count;
	} result_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== src/hlec_req_if.sv =====
// ----------------------------------------------------------------------------
// hlec_req_if
// request channel: valid, ready and one request item
// ----------------------------------------------------------------------------
interface hlec_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [hlec_pkg::KEY_W-1:0]  key;
	logic [hlec_pkg::TAG_W-1:0]  name_tag;
	logic [hlec_pkg::SLOT_W-1:0] read_index;

	modport source (output valid, req_type, key, name_tag, read_index, input ready);
	modport sink (input valid, req_type, key, name_tag, read_index, output ready);
endinterface

// ===== src/hlec_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hlec_rsp_if
// response channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface hlec_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [hlec_pkg::SLOT_W-1:0] slot;
	logic [hlec_pkg::KEY_W-1:0]  entry_key;
	logic [hlec_pkg::TAG_W-1:0]  entry_name;
	logic [hlec_pkg::CNT_W-1:0]  entry_count;

	modport source (output valid, status, slot, entry_key, entry_name, entry_count,
		input ready);
	modport sink (input valid, status, slot, entry_key, entry_name, entry_count,
		output ready);
endinterface

// ===== src/hlec_front.sv =====
// ----------------------------------------------------------------------------
// hlec_front
// accepts request items, classifies them and computes the start slot
// ----------------------------------------------------------------------------
module hlec_front (
	hlec_req_if.sink              req,
	input  hlec_pkg::back_status_t bstat,
	input  logic                  full,
	output logic                  push,
	output hlec_pkg::cmd_t        cmd
);
	logic [hlec_pkg::SLOT_W-1:0] start;

	assign req.ready = !full && !bstat.clearing;
	assign push      = req.valid && req.ready;

	// low bits of key ^ (key >> 8) ^ (key >> 16)
	assign start = req.key[8:0] ^ req.key[16:8] ^ req.key[24:16];

	always_comb begin
		cmd.key  = req.key;
		cmd.tag  = req.name_tag;
		cmd.slot = start;
		if (req.req_type[1]) begin
			cmd.kind = hlec_pkg::CMD_READ;
			cmd.slot = req.read_index;
		end else if (req.key == '0) begin
			cmd.kind = hlec_pkg::CMD_ZERO;
		end else if (req.req_type == hlec_pkg::REQ_REGISTER) begin
			cmd.kind = hlec_pkg::CMD_REGISTER;
		end else begin
			cmd.kind = hlec_pkg::CMD_EVENT;
		end
	end
endmodule

// ===== src/hlec_queue.sv =====
// ----------------------------------------------------------------------------
// hlec_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module hlec_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hlec_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output hlec_pkg::cmd_t head
);
	hlec_pkg::cmd_t ent_q [hlec_pkg::QUEUE_DEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'(hlec_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== src/hlec_back.sv =====
// ----------------------------------------------------------------------------
// hlec_back
// probes the single-port table memory and produces result items
// ----------------------------------------------------------------------------
`include "hashed_lock_event_counter_table_top_defines.svh"

module hlec_back #(
	parameter int unsigned PROBE_LIMIT = hlec_pkg::PROBE_LIMIT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  hlec_pkg::cmd_t         head,
	output logic                   pop,
	output hlec_pkg::back_status_t bstat,
	hlec_rsp_if.source             rsp
);
	localparam int unsigned PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int unsigned SW = hlec_pkg::SLOT_W;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD    = 6'b000100,
		ST_CHK   = 6'b001000,
		ST_OUT   = 6'b010000,
		ST_SPARE = 6'b100000
	} state_t;

	state_t                  st_q;
	hlec_pkg::cmd_t          cmd_q;
	hlec_pkg::result_t       res_q;
	logic [SW-1:0]           addr_q;
	logic [SW-1:0]           clr_q;
	logic [PW-1:0]           cnt_q;
	hlec_pkg::entry_t        mem [hlec_pkg::TABLE_ENTRIES];
	hlec_pkg::entry_t        rd_q;
	hlec_pkg::entry_t        wd;
	logic [SW-1:0]           wa;
	logic                    we;
	logic                    hit;
	logic [hlec_pkg::CNT_W-1:0] cnt_inc;

	assign bstat.clearing = st_q == ST_CLEAR;
	assign pop            = st_q == ST_IDLE && !empty;
	assign cnt_inc        = rd_q.count + 1'b1;

	always_comb begin
		hit = 1'b0;
		case (cmd_q.kind)
			hlec_pkg::CMD_REGISTER: hit = rd_q.key == '0;
			hlec_pkg::CMD_EVENT:    hit = rd_q.key == cmd_q.key;
			default:                hit = 1'b0;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = addr_q;
		wd = '0;
		if (st_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
		end else if (st_q == ST_CHK && hit) begin
			we = 1'b1;
			if (cmd_q.kind == hlec_pkg::CMD_REGISTER) begin
				wd = '{key: cmd_q.key, tag: cmd_q.tag, count: '0};
			end else begin
				wd = '{key: rd_q.key, tag: rd_q.tag, count: cnt_inc};
			end
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			cnt_q  <= '0;
			addr_q <= '0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!empty) begin
						addr_q <= head.slot;
						cnt_q  <= '0;
						st_q   <= (head.kind == hlec_pkg::CMD_ZERO) ? ST_OUT : ST_RD;
					end
				end
				ST_RD: st_q <= ST_CHK;
				ST_CHK: begin
					if (cmd_q.kind == hlec_pkg::CMD_READ || hit ||
						cnt_q == PW'(PROBE_LIMIT - 1)) begin
						st_q <= ST_OUT;
					end else begin
						cnt_q  <= cnt_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						st_q   <= ST_RD;
					end
				end
				ST_OUT: if (rsp.ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
			res_q <= '{status: hlec_pkg::ST_ZERO_KEY, default: '0};
		end else if (st_q == ST_CHK) begin
			if (cmd_q.kind == hlec_pkg::CMD_READ) begin
				res_q.status <= hlec_pkg::ST_OK;
				res_q.slot   <= addr_q;
				res_q.key    <= rd_q.key;
				res_q.name   <= (rd_q.key == '0) ? '0 : rd_q.tag;
				res_q.count  <= (rd_q.key == '0) ? '0 : rd_q.count;
			end else if (hit) begin
				res_q.status <= hlec_pkg::ST_OK;
				res_q.slot   <= addr_q;
				res_q.key    <= wd.key;
				res_q.name   <= wd.tag;
				res_q.count  <= wd.count;
			end else begin
				res_q <= '{status: hlec_pkg::ST_MISS, default: '0};
			end
		end
	end

	assign rsp.valid       = st_q == ST_OUT;
	assign rsp.status      = res_q.status;
	assign rsp.slot        = res_q.slot;
	assign rsp.entry_key   = res_q.key;
	assign rsp.entry_name  = res_q.name;
	assign rsp.entry_count = res_q.count;

	`HLEC_ASSERT_SAME(a_no_pop_while_clear, st_q == ST_CLEAR, !pop)
	`HLEC_ASSERT_SAME(a_write_only_clear_or_check, we, st_q == ST_CLEAR || st_q == ST_CHK)
	`HLEC_ASSERT_SAME(a_probe_bound, st_q == ST_CHK, cnt_q <= PW'(PROBE_LIMIT - 1))
	`HLEC_ASSERT_NEXT(a_read_then_check, st_q == ST_RD, st_q == ST_CHK)
endmodule

// ===== src/hashed_lock_event_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_lock_event_counter_table_top
// lock event counter table with linear probing over a single-port memory
// ----------------------------------------------------------------------------
// After reset the block sweeps the 512-entry table, clearing every key, and
// holds req.ready low meanwhile. After the pop from the queue, a zero key goes
// straight to the result, a read makes one read of the table memory and one
// check, and a register or event request probes up to PROBE_LIMIT slots: each
// probe is one read of the single-port table memory followed by a check. The
// back takes the next item from the queue in the cycle after its result is
// handed over.
// A two-entry queue lets new items be taken while a result waits on rsp.
module hashed_lock_event_counter_table_top #(
	parameter int unsigned PROBE_LIMIT = hlec_pkg::PROBE_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	hlec_req_if.sink   req,
	hlec_rsp_if.source rsp
);
	// front to queue
	logic                   push;
	hlec_pkg::cmd_t         push_cmd;
	// queue to back
	logic                   pop, full, empty;
	hlec_pkg::cmd_t         head;
	hlec_pkg::back_status_t bstat;

	// classify each item and compute the hash start slot
	hlec_front u_front (
		.req   (req),
		.bstat (bstat),
		.full  (full),
		.push  (push),
		.cmd   (push_cmd)
	);

	// decoupling queue
	hlec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	// probe sequencer and table memory
	hlec_back #(
		.PROBE_LIMIT (PROBE_LIMIT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.bstat  (bstat),
		.rsp    (rsp)
	);
endmodule
